// ===== hw/rtl/pn_pkg.sv =====
`default_nettype none

package pn_pkg;

  // Default store depth and the depths of the two internal queues.
  localparam int BUF_DEPTH_DEF = 64;
  localparam int TOKQ_DEPTH    = 4;
  localparam int OUTQ_DEPTH    = 4;

  localparam logic [7:0] SEP_CH = 8'h2F;
  localparam logic [7:0] DOT_CH = 8'h2E;

  // Byte classes assigned by the front end.
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_SEP  = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       first;
    logic [1:0] kind;
  } pn_tok_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } pn_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pn_ram.sv =====
`default_nettype none

module pn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pn_fifo.sv =====
`default_nettype none

module pn_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire logic [WIDTH-1:0]           wr_data,
  output logic                            full,
  input  wire logic                       rd_en,
  output logic      [WIDTH-1:0]           rd_data,
  output logic                            empty,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pn_front.sv =====
`default_nettype none

module pn_front
  import pn_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] in_ch,
  input  wire logic       in_is_last,
  input  wire logic       push,
  output logic            full,
  input  wire logic       tok_full,
  output logic            tok_wr,
  output pn_tok_t         tok
);

  // Set until the first nonzero byte of a path has been seen.
  logic first_r, first_nxt;

  assign full   = tok_full;
  assign tok_wr = push && !tok_full;

  always_comb begin
    tok.ch    = in_ch;
    tok.last  = in_is_last;
    tok.first = first_r;
    if (in_ch == 8'h00) begin
      tok.kind = KIND_NONE;
    end else if (in_ch == SEP_CH) begin
      tok.kind = KIND_SEP;
    end else begin
      tok.kind = KIND_DATA;
    end

    first_nxt = first_r;
    if (tok_wr) begin
      if (in_is_last) begin
        first_nxt = 1'b1;
      end else if (in_ch != 8'h00) begin
        first_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else begin
      first_r <= first_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pn_back.sv =====
`default_nettype none

module pn_back
  import pn_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF,
  parameter int OUT_DEPTH = OUTQ_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           tok_empty,
  input  wire pn_tok_t                        tok,
  output logic                                tok_rd,
  input  wire logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                                out_wr,
  output pn_out_t                             out_item
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(OUT_DEPTH + 1);
  localparam logic [AW-1:0] FULL_LVL = AW'(BUF_DEPTH - 1);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_ENDSEG  = 4'd1;
  localparam logic [3:0] ST_WRITE   = 4'd2;
  localparam logic [3:0] ST_POP_DEC = 4'd3;
  localparam logic [3:0] ST_POP_RD  = 4'd4;
  localparam logic [3:0] ST_POP_CHK = 4'd5;
  localparam logic [3:0] ST_FINAL   = 4'd6;
  localparam logic [3:0] ST_READ    = 4'd7;

  logic [3:0]      state_r, state_nxt;
  logic [AW-1:0]   fill_r, fill_nxt;
  logic [1:0]      len_r, len_nxt;
  logic            stopped_r, stopped_nxt;
  logic            last_sep_r, last_sep_nxt;
  logic            store0_sep_r, store0_sep_nxt;
  logic            endseg_r, endseg_nxt;
  logic            final_r, final_nxt;
  logic [2:0]      wcnt_r, wcnt_nxt;
  logic            inflight_r, inflight_nxt;
  logic            rd_last_r, rd_last_nxt;

  logic [7:0]      b0_r, b0_nxt;
  logic [7:0]      b1_r, b1_nxt;
  logic [3:0][7:0] wbuf_r, wbuf_nxt;
  logic [AW-1:0]   rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]   total_r, total_nxt;

  logic            we;
  logic [AW-1:0]   waddr;
  logic [7:0]      wdata;
  logic [AW-1:0]   raddr;
  logic [7:0]      rdata;

  logic            ld_en, ld_open, need_sep, go_chain, eff;
  logic [1:0]      ld_n;
  logic [7:0]      ld_b0, ld_b1, ld_b2;
  logic [CW:0]     used;
  logic            room;

  pn_ram #(
    .WIDTH ($bits(SEP_CH)),
    .DEPTH (BUF_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign used          = {1'b0, out_count} + {{CW{1'b0}}, inflight_r};
  assign room          = (used < (CW+1)'(OUT_DEPTH));
  assign out_wr        = inflight_r;
  assign out_item.ch   = rdata;
  assign out_item.last = rd_last_r;

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    len_nxt        = len_r;
    stopped_nxt    = stopped_r;
    last_sep_nxt   = last_sep_r;
    store0_sep_nxt = store0_sep_r;
    endseg_nxt     = endseg_r;
    final_nxt      = final_r;
    wcnt_nxt       = wcnt_r;
    inflight_nxt   = 1'b0;
    rd_last_nxt    = rd_last_r;
    b0_nxt         = b0_r;
    b1_nxt         = b1_r;
    wbuf_nxt       = wbuf_r;
    rd_idx_nxt     = rd_idx_r;
    total_nxt      = total_r;

    we       = 1'b0;
    waddr    = fill_r;
    wdata    = SEP_CH;
    raddr    = fill_r - AW'(1);
    tok_rd   = 1'b0;
    ld_en    = 1'b0;
    ld_open  = 1'b0;
    ld_n     = 2'd0;
    ld_b0    = 8'h00;
    ld_b1    = 8'h00;
    ld_b2    = 8'h00;
    go_chain = 1'b0;
    eff      = 1'b0;
    need_sep = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (!tok_empty) begin
          tok_rd    = 1'b1;
          go_chain  = 1'b1;
          final_nxt = tok.last;
          eff       = (tok.kind != KIND_NONE) && !stopped_r;
          if (eff) begin
            case (tok.kind)
              KIND_SEP: begin
                if (tok.first) begin
                  we             = 1'b1;
                  waddr          = '0;
                  wdata          = SEP_CH;
                  fill_nxt       = AW'(1);
                  last_sep_nxt   = 1'b1;
                  store0_sep_nxt = 1'b1;
                end
                endseg_nxt = 1'b1;
              end
              KIND_DATA: begin
                case (len_r)
                  2'd0: begin
                    b0_nxt  = tok.ch;
                    len_nxt = 2'd1;
                  end
                  2'd1: begin
                    b1_nxt  = tok.ch;
                    len_nxt = 2'd2;
                  end
                  2'd2: begin
                    // Third byte: the segment is long enough to commit now.
                    len_nxt = 2'd3;
                    ld_en   = 1'b1;
                    ld_open = 1'b1;
                    ld_n    = 2'd3;
                    ld_b0   = b0_r;
                    ld_b1   = b1_r;
                    ld_b2   = tok.ch;
                  end
                  default: begin
                    ld_en = 1'b1;
                    ld_n  = 2'd1;
                    ld_b0 = tok.ch;
                  end
                endcase
              end
              default: ;
            endcase
          end
          if (tok.last) begin
            endseg_nxt = 1'b1;
          end
        end
      end

      ST_ENDSEG: begin
        endseg_nxt = 1'b0;
        len_nxt    = 2'd0;
        go_chain   = 1'b1;
        if (!stopped_r) begin
          case (len_r)
            2'd1: begin
              if (b0_r != DOT_CH) begin
                ld_en   = 1'b1;
                ld_open = 1'b1;
                ld_n    = 2'd1;
                ld_b0   = b0_r;
              end
            end
            2'd2: begin
              if (b0_r == DOT_CH && b1_r == DOT_CH) begin
                go_chain  = 1'b0;
                state_nxt = ST_POP_DEC;
              end else begin
                ld_en   = 1'b1;
                ld_open = 1'b1;
                ld_n    = 2'd2;
                ld_b0   = b0_r;
                ld_b1   = b1_r;
              end
            end
            default: ;
          endcase
        end
      end

      ST_WRITE: begin
        if (fill_r < FULL_LVL) begin
          we           = 1'b1;
          waddr        = fill_r;
          wdata        = wbuf_r[0];
          fill_nxt     = fill_r + AW'(1);
          last_sep_nxt = (wbuf_r[0] == SEP_CH);
        end
        wbuf_nxt = {8'h00, wbuf_r[3:1]};
        wcnt_nxt = wcnt_r - 3'd1;
        if (wcnt_r == 3'd1) begin
          go_chain = 1'b1;
        end
      end

      ST_POP_DEC: begin
        if (fill_r > AW'(1)) begin
          fill_nxt  = fill_r - AW'(1);
          state_nxt = ST_POP_RD;
        end else begin
          go_chain = 1'b1;
        end
      end

      ST_POP_RD: begin
        if (fill_r > AW'(1)) begin
          raddr     = fill_r - AW'(1);
          state_nxt = ST_POP_CHK;
        end else begin
          last_sep_nxt = store0_sep_r;
          go_chain     = 1'b1;
        end
      end

      ST_POP_CHK: begin
        fill_nxt = fill_r - AW'(1);
        if (rdata == SEP_CH) begin
          last_sep_nxt = (fill_r == AW'(2)) && store0_sep_r;
          go_chain     = 1'b1;
        end else begin
          state_nxt = ST_POP_RD;
        end
      end

      ST_FINAL: begin
        final_nxt  = 1'b0;
        rd_idx_nxt = '0;
        state_nxt  = ST_READ;
        if (fill_r == '0) begin
          we             = 1'b1;
          waddr          = '0;
          wdata          = SEP_CH;
          fill_nxt       = AW'(1);
          total_nxt      = AW'(1);
          last_sep_nxt   = 1'b1;
          store0_sep_nxt = 1'b1;
        end else if (fill_r > AW'(1) && last_sep_r) begin
          fill_nxt  = fill_r - AW'(1);
          total_nxt = fill_r - AW'(1);
        end else begin
          total_nxt = fill_r;
        end
      end

      ST_READ: begin
        raddr = rd_idx_r;
        if (room) begin
          inflight_nxt = 1'b1;
          rd_last_nxt  = (rd_idx_r == total_r - AW'(1));
          rd_idx_nxt   = rd_idx_r + AW'(1);
          if (rd_idx_r == total_r - AW'(1)) begin
            fill_nxt       = '0;
            len_nxt        = 2'd0;
            stopped_nxt    = 1'b0;
            last_sep_nxt   = 1'b0;
            store0_sep_nxt = 1'b0;
            state_nxt      = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Load the write list; a separator goes first when the segment opens on a nonempty store that does not end in one.
    if (ld_en) begin
      need_sep = ld_open && (fill_r != '0) && !last_sep_r;
      if (need_sep && fill_r >= FULL_LVL) begin
        stopped_nxt = 1'b1;
        wcnt_nxt    = 3'd0;
      end else if (need_sep) begin
        wbuf_nxt = {ld_b2, ld_b1, ld_b0, SEP_CH};
        wcnt_nxt = {1'b0, ld_n} + 3'd1;
      end else begin
        wbuf_nxt = {8'h00, ld_b2, ld_b1, ld_b0};
        wcnt_nxt = {1'b0, ld_n};
      end
    end

    if (go_chain) begin
      if (wcnt_nxt != 3'd0) begin
        state_nxt = ST_WRITE;
      end else if (endseg_nxt) begin
        state_nxt = ST_ENDSEG;
      end else if (final_nxt) begin
        state_nxt = ST_FINAL;
      end else begin
        state_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      len_r        <= 2'd0;
      stopped_r    <= 1'b0;
      last_sep_r   <= 1'b0;
      store0_sep_r <= 1'b0;
      endseg_r     <= 1'b0;
      final_r      <= 1'b0;
      wcnt_r       <= 3'd0;
      inflight_r   <= 1'b0;
      rd_last_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      len_r        <= len_nxt;
      stopped_r    <= stopped_nxt;
      last_sep_r   <= last_sep_nxt;
      store0_sep_r <= store0_sep_nxt;
      endseg_r     <= endseg_nxt;
      final_r      <= final_nxt;
      wcnt_r       <= wcnt_nxt;
      inflight_r   <= inflight_nxt;
      rd_last_r    <= rd_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b0_r     <= b0_nxt;
    b1_r     <= b1_nxt;
    wbuf_r   <= wbuf_nxt;
    rd_idx_r <= rd_idx_nxt;
    total_r  <= total_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/path_normalizer.sv =====
// Streaming path normalizer. A path arrives one byte per transfer on the
// input queue (in_ch, in_is_last; push/full) and the normalized path leaves
// one byte per transfer on the result queue (out_ch, out_last; empty/pop).
// Repeated slashes collapse, "." segments vanish, and ".." removes the last
// held segment while more than one byte is held. Results appear only after
// the byte marked last; out_last marks the final result byte.
// A front end classifies each byte into a four-entry token queue, which lets
// the input side run up to four transfers ahead of the back end. The back
// end takes bytes from that queue, moves each committed write list
// (separator included) into the store byte by byte, closes each segment,
// and for a ".." pop scans the stored bytes back to the last separator.
// After the byte marked last it wraps up, then reads the store out one
// byte per cycle while the four-entry result queue has room. The store
// has a single read port and a registered read.
// Synchronous active-low reset empties both queues and clears the segment
// state; the store contents are left as they are. When the receiver stops
// popping, the result queue fills, the readout pauses, and after that the
// token queue fills and full rises until the receiver resumes.
`default_nettype none

module path_normalizer
  import pn_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] in_ch,
  input  wire logic       in_is_last,
  input  wire logic       push,
  output logic            full,
  output logic      [7:0] out_ch,
  output logic            out_last,
  output logic            empty,
  input  wire logic       pop
);

  pn_tok_t tok_in;
  pn_tok_t tok_out;
  pn_out_t res_in;
  pn_out_t res_out;

  logic                            tok_wr, tok_rd, tok_full, tok_empty;
  logic                            res_wr;
  logic [$clog2(OUTQ_DEPTH+1)-1:0] res_count;

  // Classification of incoming bytes and tracking of the path start.
  pn_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .in_is_last (in_is_last),
    .push       (push),
    .full       (full),
    .tok_full   (tok_full),
    .tok_wr     (tok_wr),
    .tok        (tok_in)
  );

  // Token queue that decouples the input transfers from the back end.
  pn_fifo #(
    .WIDTH ($bits(pn_tok_t)),
    .DEPTH (TOKQ_DEPTH)
  ) u_tokq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tok_wr),
    .wr_data (tok_in),
    .full    (tok_full),
    .rd_en   (tok_rd),
    .rd_data (tok_out),
    .empty   (tok_empty),
    .count   ()
  );

  // Segment sequencer, path store and readout.
  pn_back #(
    .BUF_DEPTH (BUF_DEPTH),
    .OUT_DEPTH (OUTQ_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_empty (tok_empty),
    .tok       (tok_out),
    .tok_rd    (tok_rd),
    .out_count (res_count),
    .out_wr    (res_wr),
    .out_item  (res_in)
  );

  // Result queue; the back end only issues a store read when a slot is free.
  pn_fifo #(
    .WIDTH ($bits(pn_out_t)),
    .DEPTH (OUTQ_DEPTH)
  ) u_resq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_wr),
    .wr_data (res_in),
    .full    (),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty),
    .count   (res_count)
  );

  assign out_ch   = res_out.ch;
  assign out_last = res_out.last;

endmodule

`default_nettype wire

// ===== hw/rtl/pn_checker.sv =====
`default_nettype none

module pn_checker
  import pn_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       full,
  input wire logic [7:0] out_ch,
  input wire logic       out_last,
  input wire logic       empty,
  input wire logic       pop
);

  // A normalized path never carries a zero byte.
  a_out_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_ch != 8'h00)
    else $error("zero byte on the result queue");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_ch) && $stable(out_last)))
    else $error("result changed while stalled");

  // Leaving reset, both queues are empty.
  a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> (empty && !full))
    else $error("queues not cleared by reset");

  // Separators never appear twice in a row within one path.
  a_no_double_sep: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !out_last && out_ch == SEP_CH) |=>
      (empty || out_ch != SEP_CH))
    else $error("two adjacent separators in the result");

endmodule

bind path_normalizer pn_checker u_pn_checker (.*);

`default_nettype wire

// ===== verif/path_normalizer_tb.sv =====
`default_nettype none

module path_normalizer_tb;
  import pn_pkg::*;

  // The block under test is built with its default store depth. One entry
  // is kept free, so a normalized path holds at most DEPTH-1 bytes.
  localparam int DEPTH       = BUF_DEPTH_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 40;
  localparam int RAND_ITEMS  = 66;
  localparam int MAX_LINES   = 40;

  typedef logic [7:0] path_t[$];

  // Scoreboard: it predicts the normalized path from every byte that
  // transfers in and keeps the expected result bytes in arrival order.
  class path_scoreboard;
    logic [7:0]  held [DEPTH];
    int unsigned held_cnt;
    logic [7:0]  seg_b0;
    logic [7:0]  seg_b1;
    int unsigned seg_len;
    bit          at_start;
    bit          halted;
    pn_out_t     due_q[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned paths;
    int unsigned pops_seen;
    int unsigned drops_seen;
    int unsigned halts_seen;

    function new();
      mismatches = 0;
      checked    = 0;
      paths      = 0;
      pops_seen  = 0;
      drops_seen = 0;
      halts_seen = 0;
      clear_path();
    endfunction

    function void clear_path();
      held_cnt = 0;
      seg_b0   = 8'h00;
      seg_b1   = 8'h00;
      seg_len  = 0;
      at_start = 1'b1;
      halted   = 1'b0;
    endfunction

    function void store_byte(logic [7:0] b);
      if (held_cnt < DEPTH - 1) begin
        held[held_cnt] = b;
        held_cnt++;
      end else begin
        drops_seen++;
      end
    endfunction

    // A separator goes in only when the store already ends in a name byte.
    // If it no longer fits, the rest of the path is ignored.
    function bit open_sep();
      if (held_cnt > 0 && held[held_cnt-1] != SEP_CH) begin
        if (held_cnt >= DEPTH - 1) begin
          halted = 1'b1;
          halts_seen++;
          return 1'b0;
        end
        held[held_cnt] = SEP_CH;
        held_cnt++;
      end
      return 1'b1;
    endfunction

    // Parent step: never takes the store below one byte, which is why a
    // leading relative segment keeps its first byte.
    function void drop_segment();
      if (held_cnt > 1) begin
        pops_seen++;
        held_cnt--;
        while (held_cnt > 1 && held[held_cnt-1] != SEP_CH) held_cnt--;
        if (held_cnt > 1 && held[held_cnt-1] == SEP_CH) held_cnt--;
      end
    endfunction

    function void close_segment();
      if (seg_len == 1) begin
        if (seg_b0 != DOT_CH && open_sep()) store_byte(seg_b0);
      end else if (seg_len == 2) begin
        if (seg_b0 == DOT_CH && seg_b1 == DOT_CH) begin
          drop_segment();
        end else if (open_sep()) begin
          store_byte(seg_b0);
          store_byte(seg_b1);
        end
      end
      seg_len = 0;
      seg_b0  = 8'h00;
      seg_b1  = 8'h00;
    endfunction

    function void take_byte(logic [7:0] c);
      case (seg_len)
        0: begin
          seg_b0  = c;
          seg_len = 1;
        end
        1: begin
          seg_b1  = c;
          seg_len = 2;
        end
        2: begin
          seg_len = 3;
          if (open_sep()) begin
            store_byte(seg_b0);
            store_byte(seg_b1);
            store_byte(c);
          end
        end
        default: store_byte(c);
      endcase
    endfunction

    function void note_byte(logic [7:0] c, logic last);
      pn_out_t e;
      if (c != 8'h00 && !halted) begin
        if (at_start && c == SEP_CH) begin
          held[0]  = SEP_CH;
          held_cnt = 1;
        end
        at_start = 1'b0;
        if (c == SEP_CH) close_segment();
        else take_byte(c);
      end
      if (last) begin
        if (!halted) close_segment();
        if (held_cnt == 0) begin
          held[0]  = SEP_CH;
          held_cnt = 1;
        end
        if (held_cnt > 1 && held[held_cnt-1] == SEP_CH) held_cnt--;
        for (int unsigned k = 0; k < held_cnt; k++) begin
          e.ch   = held[k];
          e.last = (k + 1 == held_cnt);
          due_q.push_back(e);
        end
        paths++;
        clear_path();
      end
    endfunction

    task report(string msg);
      if (mismatches < MAX_LINES) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_out(logic [7:0] c, logic last);
      pn_out_t e;
      if (due_q.size() == 0) begin
        report($sformatf("result byte %02h (last %0b) with nothing expected", c, last));
        return;
      end
      e = due_q.pop_front();
      checked++;
      if (c !== e.ch)
        report($sformatf("byte %0d: out_ch %02h, expected %02h", checked, c, e.ch));
      if (last !== e.last)
        report($sformatf("byte %0d: out_last %0b, expected %0b", checked, last, e.last));
    endtask
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic [7:0] in_ch      = 8'h00;
  logic       in_is_last = 1'b0;
  logic       push       = 1'b0;
  logic       pop        = 1'b0;
  logic       full;
  logic [7:0] out_ch;
  logic       out_last;
  logic       empty;

  path_scoreboard sb = new();

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  int unsigned items_sent   = 0;
  int unsigned quiet_cycles = 0;
  bit          hold_req     = 1'b0;
  int unsigned hold_left    = 0;

  path_normalizer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .in_is_last (in_is_last),
    .push       (push),
    .full       (full),
    .out_ch     (out_ch),
    .out_last   (out_last),
    .empty      (empty),
    .pop        (pop)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Monitor. All drivers use nonblocking assignments, so at the rising edge
  // this block still sees the values that decide the transfers of that edge.
  // The result side is checked first; a byte that transfers in at this edge
  // cannot have produced a result that leaves at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) sb.check_out(out_ch, out_last);
      if (push && !full) sb.note_byte(in_ch, in_is_last);
    end
    if (rst_n && ((pop && !empty) || (push && !full))) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // Receiver. It pops at random with the current idle ratio. A hold-off
  // request makes it stop popping for a long stretch, counted here, so the
  // result queue fills, the readout stops and the input side backs up.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= rst_n && ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: a run in which nothing transfers for too long has hung.
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("watchdog: no transfer for %0d cycles, %0d result bytes still due",
             STALL_LIMIT, sb.due_q.size());
    $display("TB_ERROR");
    $finish;
  end

  // Offers one byte and returns at the edge where it transfers. Random idle
  // cycles come before the offer, so push stays high back to back when the
  // sender is not idling.
  task automatic send_byte(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    in_ch      <= c;
    in_is_last <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_path(input path_t p);
    for (int i = 0; i < p.size(); i++) send_byte(p[i], i == p.size() - 1);
  endtask

  // It first waits for a clock edge, so the monitor has noted the last transfer
  // before the expected results are counted.
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (sb.due_q.size() != 0) @(posedge clk);
  endtask

  function automatic path_t from_text(string s);
    path_t p;
    for (int i = 0; i < s.len(); i++) p.push_back(s[i]);
    return p;
  endfunction

  // A name byte is anything but the separator and zero; dots come up often
  // enough that names like ".x" and "x." appear.
  function automatic logic [7:0] name_byte();
    logic [7:0] b;
    b = $urandom_range(1, 255);
    if (b == SEP_CH || $urandom_range(7) == 0) b = DOT_CH;
    return b;
  endfunction

  function automatic path_t name_run(int n);
    path_t p;
    repeat (n) p.push_back(name_byte());
    return p;
  endfunction

  // Random path built mostly from well-formed segments: ".", "..", short
  // and long names, with extra slashes, trailing slashes and stray zero
  // bytes mixed in as noise. Long paths can overrun the store.
  function automatic path_t rand_path(bit long_mode);
    path_t p;
    int    nseg;
    int    kind;
    if ($urandom_range(1)) p.push_back(SEP_CH);
    nseg = long_mode ? $urandom_range(3, 8) : $urandom_range(1, 5);
    for (int s = 0; s < nseg; s++) begin
      if (s > 0) p.push_back(SEP_CH);
      if ($urandom_range(5) == 0) p.push_back(SEP_CH);
      if ($urandom_range(15) == 0) p.push_back(8'h00);
      kind = $urandom_range(9);
      case (kind)
        0: p.push_back(DOT_CH);
        1, 2: begin
          p.push_back(DOT_CH);
          p.push_back(DOT_CH);
        end
        3: begin
          p.push_back(DOT_CH);
          p.push_back(name_byte());
        end
        4: begin
          p.push_back(DOT_CH);
          p.push_back(DOT_CH);
          p.push_back($urandom_range(1) ? DOT_CH : name_byte());
        end
        default: p = {p, name_run(long_mode ? $urandom_range(8, 40) : $urandom_range(1, 6))};
      endcase
    end
    if ($urandom_range(4) == 0) p.push_back(SEP_CH);
    if ($urandom_range(9) == 0) p.push_back(8'h00);
    if (p.size() == 0) p.push_back(name_byte());
    return p;
  endfunction

  // Sends whole random paths until at least count more bytes have gone in.
  task automatic random_paths(input int unsigned count);
    int unsigned upto;
    upto = items_sent + count;
    while (items_sent < upto) send_path(rand_path($urandom_range(6) == 0));
  endtask

  initial begin
    path_t p;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed paths, sent with both sides idling now and then.
    tx_idle_pct = 27;
    rx_idle_pct = 73;
    send_path(from_text("/"));       // root alone
    send_path(from_text("."));       // nothing held at the end gives "/"
    send_path(from_text("ab/.."));   // a first relative segment keeps one byte
    send_path(from_text("//x/"));    // collapsed slashes, trailing slash dropped
    send_path(from_text("/a/.."));   // parent step back to the root
    p = {8'h00};                     // zero byte that only ends the path
    send_path(p);
    p = {8'hFF, 8'h01};              // byte extremes
    send_path(p);
    send_path(from_text("..."));     // three dots are an ordinary name
    p = {SEP_CH, 8'h71, 8'h00};      // zero byte carrying the last flag
    send_path(p);
    send_path(from_text("./b"));

    // First random phase: sender idles little, receiver much.
    random_paths(RAND_ITEMS / 3);

    // Pressure: the receiver stops popping for a long stretch while the
    // sender offers bytes back to back. The first long path fills the store
    // so that its next separator cannot fit, the second overruns the store
    // with one long name and then steps back to the parent.
    wait_drained();
    tx_idle_pct = 0;
    hold_req    = 1'b1;
    send_path({from_text("/"), name_run(62), from_text("/xy/q")});
    send_path({name_run(66), from_text("/..")});
    // Pause on the input side until every result has arrived.
    wait_drained();

    // Second random phase: the idle ratios swap.
    tx_idle_pct = 73;
    rx_idle_pct = 27;
    random_paths(RAND_ITEMS / 3);

    // Last phase: no idling on either side.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_paths(RAND_ITEMS / 3);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.due_q.size() != 0)
      sb.report($sformatf("%0d result bytes never arrived", sb.due_q.size()));

    $display("run covered %0d paths from %0d input bytes, %0d result bytes checked",
             sb.paths, items_sent, sb.checked);
    $display("parent steps %0d, bytes dropped on a full store %0d, separator stops %0d",
             sb.pops_seen, sb.drops_seen, sb.halts_seen);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
